// ----- src/mtc_pkg.sv -----
// Shared types, character constants and Morse tables of the Morse text codec.
package mtc_pkg;

	// ASCII codes used by the codec
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChCr    = 8'h0D;

	// Code table size and longest code
	localparam int CodeCount  = 36;
	localparam int LetterCount = 26;
	localparam int MaxSymbols = 5;

	// Number of spaces emitted for whitespace in encode mode
	localparam logic [2:0] WhiteSpaces = 3'd3;

	// One Morse code: symbol count and symbols, bit i is symbol i (1 = dash)
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] pat;
	} code_t;

	// How a burst of results is built
	typedef enum logic [1:0] {
		KIND_SYM   = 2'd0,	// symbols then one space
		KIND_SPACE = 2'd1,	// spaces only
		KIND_CHAR  = 2'd2	// one decoded character
	} kind_t;

	// Burst descriptor handed from the front end to the serialiser
	typedef struct packed {
		kind_t      kind;
		logic [2:0] count;
		logic [4:0] sym;
		logic [7:0] chr;
	} desc_t;

	// ITU Morse table: A..Z then 0..9
	function automatic code_t morse_entry(input logic [5:0] idx);
		code_t e;
		unique case (idx)
			6'd0:  e = '{3'd2, 5'b00010};	// A .-
			6'd1:  e = '{3'd4, 5'b00001};	// B -...
			6'd2:  e = '{3'd4, 5'b00101};	// C -.-.
			6'd3:  e = '{3'd3, 5'b00001};	// D -..
			6'd4:  e = '{3'd1, 5'b00000};	// E .
			6'd5:  e = '{3'd4, 5'b00100};	// F ..-.
			6'd6:  e = '{3'd3, 5'b00011};	// G --.
			6'd7:  e = '{3'd4, 5'b00000};	// H ....
			6'd8:  e = '{3'd2, 5'b00000};	// I ..
			6'd9:  e = '{3'd4, 5'b01110};	// J .---
			6'd10: e = '{3'd3, 5'b00101};	// K -.-
			6'd11: e = '{3'd4, 5'b00010};	// L .-..
			6'd12: e = '{3'd2, 5'b00011};	// M --
			6'd13: e = '{3'd2, 5'b00001};	// N -.
			6'd14: e = '{3'd3, 5'b00111};	// O ---
			6'd15: e = '{3'd4, 5'b00110};	// P .--.
			6'd16: e = '{3'd4, 5'b01011};	// Q --.-
			6'd17: e = '{3'd3, 5'b00010};	// R .-.
			6'd18: e = '{3'd3, 5'b00000};	// S ...
			6'd19: e = '{3'd1, 5'b00001};	// T -
			6'd20: e = '{3'd3, 5'b00100};	// U ..-
			6'd21: e = '{3'd4, 5'b01000};	// V ...-
			6'd22: e = '{3'd3, 5'b00110};	// W .--
			6'd23: e = '{3'd4, 5'b01001};	// X -..-
			6'd24: e = '{3'd4, 5'b01101};	// Y -.--
			6'd25: e = '{3'd4, 5'b00011};	// Z --..
			6'd26: e = '{3'd5, 5'b11111};	// 0 -----
			6'd27: e = '{3'd5, 5'b11110};	// 1 .----
			6'd28: e = '{3'd5, 5'b11100};	// 2 ..---
			6'd29: e = '{3'd5, 5'b11000};	// 3 ...--
			6'd30: e = '{3'd5, 5'b10000};	// 4 ....-
			6'd31: e = '{3'd5, 5'b00000};	// 5 .....
			6'd32: e = '{3'd5, 5'b00001};	// 6 -....
			6'd33: e = '{3'd5, 5'b00011};	// 7 --...
			6'd34: e = '{3'd5, 5'b00111};	// 8 ---..
			6'd35: e = '{3'd5, 5'b01111};	// 9 ----.
			default: e = '{3'd0, 5'b00000};
		endcase
		return e;
	endfunction

	// Character for a table index
	function automatic logic [7:0] char_of_index(input logic [5:0] idx);
		logic [7:0] c;
		if (idx < 6'(LetterCount))
			c = ChUpA + {2'b00, idx};
		else
			c = ChZero + {2'b00, idx} - 8'(LetterCount);
		return c;
	endfunction

	// Whitespace: tab, line feed, vertical tab, form feed, carriage return, space
	function automatic logic is_white(input logic [7:0] c);
		return (c == ChSpace) || (c >= ChTab && c <= ChCr);
	endfunction

endpackage

// ----- src/morse_text_codec.sv -----
// Top level of the Morse text codec.
// Takes one ASCII item per cycle while the descriptor slot is free and gives one result item
// per cycle while the receiver is ready: a letter or digit in encode mode gives its symbols
// and one space, whitespace three spaces, a decoded character one result, and an item with no
// result gives none. The output serialiser, one result per cycle, sets the sustained rate;
// a one-descriptor skid slot lets the next item enter while a burst is still being taken.
// An accepted item passes the skid slot, then the active burst, before its first result.
module morse_text_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	logic           accept, desc_push, slot_ready;
	mtc_pkg::desc_t desc;

	assign in_ready = slot_ready;
	assign accept   = in_valid && slot_ready;

	mtc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.line_end  (line_end),
		.desc_push (desc_push),
		.desc      (desc)
	);

	mtc_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (desc_push),
		.desc        (desc),
		.slot_ready  (slot_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

// ----- src/mtc_front.sv -----
// Front end of the Morse text codec: line state, pending code and burst descriptors.
module mtc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          char_code,
	input  logic                line_end,
	output logic                desc_push,
	output mtc_pkg::desc_t      desc
);

	logic       decode_mode_q, at_line_start_q, pending_invalid_q;
	logic [4:0] pending_symbols_q;
	logic [2:0] pending_length_q;

	logic       decode_mode_d, at_line_start_d, pending_invalid_d;
	logic [4:0] pending_symbols_d;
	logic [2:0] pending_length_d;

	logic [7:0] c_up;
	logic       is_sym, is_dash, white, mode_eff;
	logic       hit;
	logic [7:0] hit_chr;
	logic       flush_ok;
	logic [5:0] enc_idx;
	logic       enc_ok;
	mtc_pkg::code_t enc_code;
	mtc_pkg::code_t key;

	// fold lower case and classify the character
	always_comb begin
		c_up = char_code;
		if (char_code >= mtc_pkg::ChLowA && char_code <= mtc_pkg::ChLowZ)
			c_up = char_code - 8'h20;
		is_dash  = (c_up == mtc_pkg::ChDash);
		is_sym   = is_dash || (c_up == mtc_pkg::ChDot);
		white    = mtc_pkg::is_white(c_up);
		mode_eff = at_line_start_q ? is_sym : decode_mode_q;
	end

	// decode lookup of the pending code against every table entry in parallel
	always_comb begin
		key     = '{pending_length_q, pending_symbols_q};
		hit     = 1'b0;
		hit_chr = 8'h00;
		for (int i = 0; i < mtc_pkg::CodeCount; i++) begin
			if (mtc_pkg::morse_entry(6'(i)) == key) begin
				hit     = 1'b1;
				hit_chr = mtc_pkg::char_of_index(6'(i));
			end
		end
		flush_ok = hit && !pending_invalid_q && pending_length_q != 3'd0 &&
			pending_length_q <= 3'(mtc_pkg::MaxSymbols);
	end

	// encode index of a letter or digit
	always_comb begin
		enc_ok  = 1'b1;
		enc_idx = 6'd0;
		if (c_up >= mtc_pkg::ChUpA && c_up <= mtc_pkg::ChUpZ)
			enc_idx = 6'(c_up - mtc_pkg::ChUpA);
		else if (c_up >= mtc_pkg::ChZero && c_up <= mtc_pkg::ChNine)
			enc_idx = 6'(c_up - mtc_pkg::ChZero) + 6'(mtc_pkg::LetterCount);
		else
			enc_ok = 1'b0;
		enc_code = mtc_pkg::morse_entry(enc_idx);
	end

	// next state and burst descriptor
	always_comb begin
		decode_mode_d     = decode_mode_q;
		at_line_start_d   = at_line_start_q;
		pending_symbols_d = pending_symbols_q;
		pending_length_d  = pending_length_q;
		pending_invalid_d = pending_invalid_q;
		desc.kind  = mtc_pkg::KIND_CHAR;
		desc.count = 3'd0;
		desc.sym   = enc_code.pat;
		desc.chr   = hit_chr;
		if (line_end) begin
			if (decode_mode_q && flush_ok)
				desc.count = 3'd1;
			pending_symbols_d = '0;
			pending_length_d  = '0;
			pending_invalid_d = 1'b0;
			decode_mode_d     = 1'b0;
			at_line_start_d   = 1'b1;
		end else begin
			decode_mode_d   = mode_eff;
			at_line_start_d = 1'b0;
			if (mode_eff) begin
				if (white) begin
					if (flush_ok)
						desc.count = 3'd1;
					pending_symbols_d = '0;
					pending_length_d  = '0;
					pending_invalid_d = 1'b0;
				end else begin
					if (!is_sym)
						pending_invalid_d = 1'b1;
					else if (is_dash && pending_length_q < 3'(mtc_pkg::MaxSymbols))
						pending_symbols_d = pending_symbols_q |
							(5'b00001 << pending_length_q);
					if (pending_length_q != 3'd7)
						pending_length_d = pending_length_q + 3'd1;
				end
			end else if (white) begin
				desc.kind  = mtc_pkg::KIND_SPACE;
				desc.count = mtc_pkg::WhiteSpaces;
			end else if (enc_ok) begin
				desc.kind  = mtc_pkg::KIND_SYM;
				desc.count = enc_code.len + 3'd1;
			end
		end
		desc_push = accept && (desc.count != 3'd0);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q     <= 1'b0;
			at_line_start_q   <= 1'b1;
			pending_symbols_q <= '0;
			pending_length_q  <= '0;
			pending_invalid_q <= 1'b0;
		end else if (accept) begin
			decode_mode_q     <= decode_mode_d;
			at_line_start_q   <= at_line_start_d;
			pending_symbols_q <= pending_symbols_d;
			pending_length_q  <= pending_length_d;
			pending_invalid_q <= pending_invalid_d;
		end
	end

	// a line end always leaves the block in encode mode at a line start
	a_line_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end |=> at_line_start_q && !decode_mode_q &&
			pending_length_q == 3'd0)
		else $error("line end did not reset the line state");

endmodule

// ----- src/mtc_serial.sv -----
// Burst serialiser of the Morse text codec: descriptor skid slot and result generation.
module mtc_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mtc_pkg::desc_t      desc,
	output logic                slot_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_char,
	output logic                last_of_run
);

	mtc_pkg::desc_t d_q, a_q;
	logic           d_valid_q, a_valid_q;
	logic [2:0]     idx_q;
	logic           last, a_done, a_free, load_a;

	// burst progress
	always_comb begin
		last       = (idx_q == a_q.count - 3'd1);
		a_done     = a_valid_q && out_ready && last;
		a_free     = !a_valid_q || a_done;
		load_a     = d_valid_q && a_free;
		slot_ready = !d_valid_q || a_free;
	end

	// result for the current position of the burst
	always_comb begin
		out_valid   = a_valid_q;
		last_of_run = last;
		unique case (a_q.kind)
			mtc_pkg::KIND_SYM:
				if (last)
					out_char = mtc_pkg::ChSpace;
				else
					out_char = a_q.sym[idx_q] ? mtc_pkg::ChDash : mtc_pkg::ChDot;
			mtc_pkg::KIND_CHAR:  out_char = a_q.chr;
			default:             out_char = mtc_pkg::ChSpace;
		endcase
	end

	// valid flags and position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_valid_q <= 1'b0;
			a_valid_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			d_valid_q <= push || (d_valid_q && !a_free);
			if (load_a) begin
				a_valid_q <= 1'b1;
				idx_q     <= '0;
			end else if (a_done) begin
				a_valid_q <= 1'b0;
				idx_q     <= '0;
			end else if (a_valid_q && out_ready) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// descriptor payloads
	always_ff @(posedge clk) begin
		if (push)
			d_q <= desc;
		if (load_a)
			a_q <= d_q;
	end

	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid_q |-> (a_q.count != 3'd0) && (idx_q < a_q.count))
		else $error("burst position outside its count");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		d_valid_q && !a_valid_q |=> a_valid_q)
		else $error("waiting descriptor not moved to the active burst");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_ready)
		else $error("descriptor pushed into a full slot");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the Morse text codec: result predictor, item drivers and watchdog.
module tb_top;

	localparam int ItemTarget = 230;
	localparam int HoldCycles = 120;
	localparam int IdleLimit  = 1500;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} result_t;

	// Predicts the output characters of each item and checks them in order
	class morse_checker;
		result_t    expected_chars[$];
		logic [7:0] burst[$];
		int         errors;
		logic       decode_mode;
		logic       at_line_start;
		logic       pending_invalid;
		logic [4:0] pending_symbols;
		logic [2:0] pending_length;

		function new();
			errors = 0;
			decode_mode = 1'b0;
			at_line_start = 1'b1;
			clear_code();
		endfunction

		function void clear_code();
			pending_symbols = '0;
			pending_length = '0;
			pending_invalid = 1'b0;
		endfunction

		// ITU Morse, letters first then digits
		function string morse_of(input int idx);
			case (idx)
				0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
				4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
				8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
				12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
				16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
				20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
				24: return "-.--";  25: return "--..";  26: return "-----"; 27: return ".----";
				28: return "..---"; 29: return "...--"; 30: return "....-"; 31: return ".....";
				32: return "-...."; 33: return "--..."; 34: return "---.."; 35: return "----.";
				default: return "";
			endcase
		endfunction

		function logic white(input logic [7:0] c);
			return (c == mtc_pkg::ChSpace) || (c >= mtc_pkg::ChTab && c <= mtc_pkg::ChCr);
		endfunction

		function void push_char(input logic [7:0] c);
			burst.push_back(c);
		endfunction

		// Look the pending code up, emit its character on a match, then clear it
		function void flush_code();
			string      s;
			logic [4:0] pat;
			logic [7:0] c;
			if (pending_length != 0 && pending_length <= mtc_pkg::MaxSymbols &&
					!pending_invalid) begin
				for (int idx = 0; idx < mtc_pkg::CodeCount; idx++) begin
					s = morse_of(idx);
					pat = '0;
					for (int n = 0; n < s.len(); n++)
						if (s[n] == mtc_pkg::ChDash) pat[n] = 1'b1;
					if (s.len() == pending_length && pat == pending_symbols) begin
						if (idx < mtc_pkg::LetterCount) c = mtc_pkg::ChUpA + 8'(idx);
						else c = mtc_pkg::ChZero + 8'(idx - mtc_pkg::LetterCount);
						push_char(c);
						break;
					end
				end
			end
			clear_code();
		endfunction

		// Accepted input item: advance the line state and queue its results
		function void note_item(input logic [7:0] c, input logic e);
			logic [7:0] ch;
			logic [7:0] nxt;
			int         idx;
			string      s;
			result_t    r;
			ch = c;
			idx = -1;
			if (e) begin
				if (decode_mode) flush_code();
				clear_code();
				decode_mode = 1'b0;
				at_line_start = 1'b1;
			end else begin
				if (ch >= mtc_pkg::ChLowA && ch <= mtc_pkg::ChLowZ) ch = ch - 8'd32;
				if (at_line_start) begin
					decode_mode = (ch == mtc_pkg::ChDot || ch == mtc_pkg::ChDash);
					at_line_start = 1'b0;
				end
				if (decode_mode) begin
					if (white(ch)) flush_code();
					else begin
						if (ch != mtc_pkg::ChDot && ch != mtc_pkg::ChDash)
							pending_invalid = 1'b1;
						else if (pending_length < mtc_pkg::MaxSymbols && ch == mtc_pkg::ChDash)
							pending_symbols[pending_length] = 1'b1;
						if (pending_length < 3'd7) pending_length = pending_length + 3'd1;
					end
				end else if (white(ch)) begin
					repeat (mtc_pkg::WhiteSpaces) push_char(mtc_pkg::ChSpace);
				end else begin
					if (ch >= mtc_pkg::ChUpA && ch <= mtc_pkg::ChUpZ)
						idx = int'(ch - mtc_pkg::ChUpA);
					else if (ch >= mtc_pkg::ChZero && ch <= mtc_pkg::ChNine)
						idx = mtc_pkg::LetterCount + int'(ch - mtc_pkg::ChZero);
					if (idx >= 0) begin
						s = morse_of(idx);
						for (int n = 0; n < s.len(); n++) push_char(s[n]);
						push_char(mtc_pkg::ChSpace);
					end
				end
			end
			// move the burst over, flagging its final character
			while (burst.size() != 0) begin
				nxt = burst.pop_front();
				r.ch = nxt;
				r.last = (burst.size() == 0);
				expected_chars.push_back(r);
			end
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(input logic [7:0] ch, input logic last);
			result_t r;
			if (expected_chars.size() == 0) begin
				report($sformatf("unexpected result char=%h last=%b", ch, last));
			end else begin
				r = expected_chars.pop_front();
				if (r.ch !== ch)
					report($sformatf("out_char got %h want %h", ch, r.ch));
				if (r.last !== last)
					report($sformatf("last_of_run got %b want %b (char %h)", last, r.last, r.ch));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'h00;
	logic       line_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       last_of_run;

	morse_checker sb;
	int   sent = 0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	int   rx_gap = 0;
	int   idle_cycles = 0;

	morse_text_codec dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.last_of_run(last_of_run)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] pick_white();
		int r;
		r = $urandom_range(0, 5);
		if (r == 5) return mtc_pkg::ChSpace;
		return mtc_pkg::ChTab + 8'(r);
	endfunction

	function automatic logic [7:0] pick_alnum();
		case ($urandom_range(0, 2))
			0: return mtc_pkg::ChUpA + 8'($urandom_range(0, 25));
			1: return mtc_pkg::ChLowA + 8'($urandom_range(0, 25));
			default: return mtc_pkg::ChZero + 8'($urandom_range(0, 9));
		endcase
	endfunction

	// One input item, held until accepted
	task automatic send_item(input logic [7:0] c, input logic e);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		line_end <= e;
		do @(posedge clk); while (!in_ready);
		sb.note_item(c, e);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	// Receiver: random stalls plus one long hold-off on request; checks each result
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_char, last_of_run);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req <= 1'b0;
				hold_left <= HoldCycles - 1;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				rx_gap <= pick_gap();
			end
		end
	end

	// Watchdog on cycles with no item moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int line;
		int kind;
		int len;
		int n_codes;
		int corrupt;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode: case folding, letter, digit, whitespace, dropped characters
		send_text("aZ9 \t!");
		send_item(8'hFF, 1'b0);
		send_item(8'hA5, 1'b1);
		// decode: a letter, then a digit flushed by the line end
		send_text(".- -----");
		send_item(8'h00, 1'b1);
		// decode: too long a code, a foreign character, an empty code
		send_text(".-.-.-- .x  ");
		send_item(8'h5A, 1'b1);
		// line end with nothing pending
		send_item(8'h00, 1'b1);

		line = 0;
		while (sent < ItemTarget) begin
			if (line == 4) hold_req <= 1'b1;
			calm = (line >= 12 && line < 22);
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				// encode line
				len = $urandom_range(1, 8);
				send_item(pick_alnum(), 1'b0);
				for (int i = 1; i < len; i++) begin
					case ($urandom_range(0, 4))
						0: send_item(pick_white(), 1'b0);
						1: send_item(8'($urandom_range(0, 255)), 1'b0);
						default: send_item(pick_alnum(), 1'b0);
					endcase
				end
			end else if (kind < 90) begin
				// decode line: codes split by whitespace, now and then spoilt
				n_codes = $urandom_range(1, 4);
				for (int k = 0; k < n_codes; k++) begin
					send_text(sb.morse_of($urandom_range(0, mtc_pkg::CodeCount - 1)));
					corrupt = $urandom_range(0, 9);
					if (corrupt == 0) send_text("-.-.-");
					else if (corrupt == 1)
						send_item(8'($urandom_range(mtc_pkg::ChUpA, mtc_pkg::ChLowZ)), 1'b0);
					if (k < n_codes - 1 || $urandom_range(0, 1)) begin
						send_item(pick_white(), 1'b0);
						if ($urandom_range(0, 7) == 0) send_item(pick_white(), 1'b0);
					end
				end
			end else begin
				// raw bytes
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), 1'b0);
			end
			send_item(8'($urandom_range(0, 255)), 1'b1);
			line++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain, then give stray results time to show
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/mtc_pkg.sv
src/mtc_front.sv
src/mtc_serial.sv
src/morse_text_codec.sv
verif/tb_top.sv
